>>> rtl/secn_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// secn_pkg
// Types and constants for the sojourn-time ECN marking descriptor FIFO.
// ---------------------------------------------------------------------------
package secn_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DROP  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // ECN codepoints
    localparam logic [1:0] ECN_ECT_ONE = 2'd1;
    localparam logic [1:0] ECN_CE      = 2'd3;

    // fixed field widths
    localparam int SIZE_W   = 16;
    localparam int ECN_W    = 2;
    localparam int MAXP_W   = 8;
    localparam int MAXB_W   = 24;
    localparam int THR_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKTS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_THR  = 3'd4;

    // register reset values
    localparam logic              LIMIT_MODE_RST = 1'b0;
    localparam logic [MAXP_W-1:0] MAX_PKTS_RST   = 8'd100;
    localparam logic [MAXB_W-1:0] MAX_BYTES_RST  = 24'd150000;
    localparam logic [THR_W-1:0]  MARK_THR_RST   = 32'd10000;
    localparam logic [THR_W-1:0]  BURST_THR_RST  = 32'd50000;

endpackage : secn_pkg
`default_nettype wire

>>> rtl/sojourn_ecn_marking_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sojourn_ecn_marking_fifo
// Drop-tail descriptor FIFO with sojourn-time ECN marking and microburst
// detection.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one transaction per
//   operation: opcode 0 enqueues pkt_handle, pkt_size and ecn_in stamped with
//   now_ns, opcode 1 dequeues the head using now_ns as the current time.
//   Every input transaction produces exactly one output transaction
//   (out_valid / out_stall) carrying the status and, for a dequeue, the
//   descriptor, marked ECN, sojourn time and microburst end report.
//   Input acceptance loads the read stage with the synchronous read of the
//   stamp and descriptor memories; the sojourn subtract and threshold compares
//   then feed the output register, which drives out_valid.
//   Throughput is one transaction per cycle while out_stall is low; the held
//   memory read data plus the stage register let a new transaction be
//   accepted while a result waits in the output register. While out_stall
//   holds a waiting result, in_stall is high in every cycle in which the
//   stage is occupied, from the same cycle as out_stall.
//   Reset empties the queue, clears the burst state and loads the register
//   defaults; the memories are not cleared since only written entries are read.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
//   next clock edge and are expected only while the block is idle.
// ---------------------------------------------------------------------------
module sojourn_ecn_marking_fifo
    import secn_pkg::*;
#(
    parameter int FIFO_DEPTH   = 128,
    parameter int TIME_WIDTH   = 48,
    parameter int HANDLE_WIDTH = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    opcode,
    input  wire logic [TIME_WIDTH-1:0]   now_ns,
    input  wire logic [HANDLE_WIDTH-1:0] pkt_handle,
    input  wire logic [SIZE_W-1:0]       pkt_size,
    input  wire logic [ECN_W-1:0]        ecn_in,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   status,
    output logic [HANDLE_WIDTH-1:0]      out_handle,
    output logic [SIZE_W-1:0]            out_size,
    output logic [ECN_W-1:0]             ecn_out,
    output logic                         was_marked,
    output logic [TIME_WIDTH-1:0]        sojourn_ns,
    output logic                         burst_ended,
    output logic [TIME_WIDTH-1:0]        burst_start_ns
);

    localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int BYTE_W  = $clog2(FIFO_DEPTH * 65535 + 1);
    localparam int PCMP_W  = ((CNT_W > MAXP_W) ? CNT_W : MAXP_W) + 1;
    localparam int BCMP_W  = ((BYTE_W > MAXB_W) ? BYTE_W : MAXB_W) + 1;
    localparam int DESC_W  = HANDLE_WIDTH + SIZE_W + ECN_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // storage
    logic [TIME_WIDTH-1:0] stamp_mem [FIFO_DEPTH];
    logic [DESC_W-1:0]     desc_mem  [FIFO_DEPTH];

    // configuration
    logic              limit_mode_reg;
    logic [MAXP_W-1:0] max_pkts_reg;
    logic [MAXB_W-1:0] max_bytes_reg;
    logic [THR_W-1:0]  mark_thr_reg;
    logic [THR_W-1:0]  burst_thr_reg;

    // queue state
    logic [PTR_W-1:0]      head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]      tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]      pkt_count_reg, pkt_count_next;
    logic [BYTE_W-1:0]     byte_count_reg, byte_count_next;
    logic                  burst_active_reg, burst_active_next;
    logic [TIME_WIDTH-1:0] burst_start_reg, burst_start_next;

    // read stage
    logic                    s1_vld_reg, s1_vld_next;
    status_t                 s1_status_reg;
    logic [TIME_WIDTH-1:0]   s1_now_reg;
    logic [TIME_WIDTH-1:0]   rd_stamp_reg;
    logic [HANDLE_WIDTH-1:0] rd_handle_reg;
    logic [SIZE_W-1:0]       rd_size_reg;
    logic [ECN_W-1:0]        rd_ecn_reg;

    // output register
    logic                    out_vld_reg, out_vld_next;
    status_t                 out_status_reg;
    logic [HANDLE_WIDTH-1:0] out_handle_reg;
    logic [SIZE_W-1:0]       out_size_reg;
    logic [ECN_W-1:0]        out_ecn_reg;
    logic                    out_marked_reg;
    logic [TIME_WIDTH-1:0]   out_sojourn_reg;
    logic                    out_ended_reg;
    logic [TIME_WIDTH-1:0]   out_bstart_reg;

    // combinational
    logic                  in_acc;
    logic                  s1_adv;
    logic                  s1_is_deq;
    logic                  do_enq;
    logic                  do_deq;
    logic                  drop;
    status_t               acc_status;
    logic [BYTE_W-1:0]     byte_dec;
    logic [BYTE_W-1:0]     byte_eff;
    logic [TIME_WIDTH-1:0] soj;
    logic                  soj_over_mark;
    logic                  soj_over_burst;
    logic                  soj_under_burst;
    logic                  mark;
    logic                  burst_begin;
    logic                  burst_end;

    assign in_acc    = in_valid && !in_stall;
    assign s1_adv    = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = s1_vld_reg && !s1_adv;
    assign s1_is_deq = (s1_status_reg == ST_DEQ);

    // sojourn and threshold compares on the read stage
    assign soj             = s1_now_reg - rd_stamp_reg;
    assign soj_over_mark   = soj > TIME_WIDTH'(mark_thr_reg);
    assign soj_over_burst  = soj > TIME_WIDTH'(burst_thr_reg);
    assign soj_under_burst = soj < TIME_WIDTH'(burst_thr_reg);
    assign mark        = s1_is_deq && soj_over_mark && (rd_ecn_reg == ECN_ECT_ONE);
    assign burst_begin = s1_is_deq && soj_over_burst && !burst_active_reg;
    assign burst_end   = s1_is_deq && burst_active_reg && soj_under_burst;

    // byte count as it stands once the dequeue in the read stage retires
    assign byte_dec = (s1_adv && s1_is_deq) ? BYTE_W'(rd_size_reg) : '0;
    assign byte_eff = byte_count_reg - byte_dec;

    always_comb
    begin
        drop = 1'b0;
        if (pkt_count_reg == CNT_FULL)
        begin
            drop = 1'b1;
        end
        else if (limit_mode_reg)
        begin
            drop = (PCMP_W'(pkt_count_reg) + PCMP_W'(1)) > PCMP_W'(max_pkts_reg);
        end
        else
        begin
            drop = (BCMP_W'(byte_eff) + BCMP_W'(pkt_size)) > BCMP_W'(max_bytes_reg);
        end

        if (opcode == OP_ENQ)
        begin
            acc_status = drop ? ST_DROP : ST_ENQ;
        end
        else
        begin
            acc_status = (pkt_count_reg == '0) ? ST_EMPTY : ST_DEQ;
        end

        do_enq = in_acc && (acc_status == ST_ENQ);
        do_deq = in_acc && (acc_status == ST_DEQ);

        head_ptr_next  = head_ptr_reg;
        tail_ptr_next  = tail_ptr_reg;
        pkt_count_next = pkt_count_reg;
        byte_count_next = byte_eff;
        if (do_enq)
        begin
            tail_ptr_next   = (tail_ptr_reg == PTR_LAST) ? '0 : tail_ptr_reg + PTR_W'(1);
            pkt_count_next  = pkt_count_reg + CNT_W'(1);
            byte_count_next = byte_eff + BYTE_W'(pkt_size);
        end
        if (do_deq)
        begin
            head_ptr_next  = (head_ptr_reg == PTR_LAST) ? '0 : head_ptr_reg + PTR_W'(1);
            pkt_count_next = pkt_count_reg - CNT_W'(1);
        end

        burst_active_next = burst_active_reg;
        burst_start_next  = burst_start_reg;
        if (s1_adv && burst_begin)
        begin
            burst_active_next = 1'b1;
            burst_start_next  = s1_now_reg;
        end
        else if (s1_adv && burst_end)
        begin
            burst_active_next = 1'b0;
        end

        s1_vld_next = s1_vld_reg;
        if (in_acc)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (s1_adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_mode_reg <= LIMIT_MODE_RST;
            max_pkts_reg   <= MAX_PKTS_RST;
            max_bytes_reg  <= MAX_BYTES_RST;
            mark_thr_reg   <= MARK_THR_RST;
            burst_thr_reg  <= BURST_THR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LIMIT_MODE: limit_mode_reg <= cfg_data[0];
                CFG_MAX_PKTS:   max_pkts_reg   <= cfg_data[MAXP_W-1:0];
                CFG_MAX_BYTES:  max_bytes_reg  <= cfg_data[MAXB_W-1:0];
                CFG_MARK_THR:   mark_thr_reg   <= cfg_data[THR_W-1:0];
                CFG_BURST_THR:  burst_thr_reg  <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg     <= '0;
            tail_ptr_reg     <= '0;
            pkt_count_reg    <= '0;
            byte_count_reg   <= '0;
            burst_active_reg <= 1'b0;
            burst_start_reg  <= '0;
            s1_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            head_ptr_reg     <= head_ptr_next;
            tail_ptr_reg     <= tail_ptr_next;
            pkt_count_reg    <= pkt_count_next;
            byte_count_reg   <= byte_count_next;
            burst_active_reg <= burst_active_next;
            burst_start_reg  <= burst_start_next;
            s1_vld_reg       <= s1_vld_next;
            out_vld_reg      <= out_vld_next;
        end
    end

    // memory write at the tail
    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            stamp_mem[tail_ptr_reg] <= now_ns;
            desc_mem[tail_ptr_reg]  <= {pkt_handle, pkt_size, ecn_in};
        end
    end

    // memory read at the head, held while the stage waits
    always_ff @(posedge clk)
    begin
        if (do_deq)
        begin
            rd_stamp_reg <= stamp_mem[head_ptr_reg];
            {rd_handle_reg, rd_size_reg, rd_ecn_reg} <= desc_mem[head_ptr_reg];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_status_reg <= acc_status;
            s1_now_reg    <= now_ns;
        end
    end

    // output payload, all but the status zero for anything but a dequeue
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_status_reg  <= s1_status_reg;
            out_handle_reg  <= s1_is_deq ? rd_handle_reg : '0;
            out_size_reg    <= s1_is_deq ? rd_size_reg : '0;
            out_ecn_reg     <= s1_is_deq ? (mark ? ECN_CE : rd_ecn_reg) : '0;
            out_marked_reg  <= mark;
            out_sojourn_reg <= s1_is_deq ? soj : '0;
            out_ended_reg   <= burst_end;
            out_bstart_reg  <= burst_end ? burst_start_reg : '0;
        end
    end

    assign out_valid      = out_vld_reg;
    assign status         = out_status_reg;
    assign out_handle     = out_handle_reg;
    assign out_size       = out_size_reg;
    assign ecn_out        = out_ecn_reg;
    assign was_marked     = out_marked_reg;
    assign sojourn_ns     = out_sojourn_reg;
    assign burst_ended    = out_ended_reg;
    assign burst_start_ns = out_bstart_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_count_reg <= CNT_FULL)
        else $error("packet count beyond fifo depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_count_reg == '0) |-> (head_ptr_reg == tail_ptr_reg))
        else $error("empty queue with head and tail apart");

    a_empty_deq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (opcode == OP_DEQ) && (pkt_count_reg == '0))
            |=> $stable(pkt_count_reg))
        else $error("dequeue on empty queue changed the count");

    a_mark_ce: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_marked_reg) |-> (out_ecn_reg == ECN_CE))
        else $error("marked result without CE");

    a_end_on_deq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_ended_reg) |-> (out_status_reg == ST_DEQ))
        else $error("burst end reported on a non-dequeue");

endmodule : sojourn_ecn_marking_fifo
`default_nettype wire
